// File: rtl/eti_pkg.sv
// Shared types, constants and table-building functions for the easing tween block.
// Used by eti_ctrl, eti_dp and easing_tween_interpolator_top.
package eti_pkg;

  localparam logic [63:0] ONE30     = 64'd1073741824;
  localparam logic [63:0] PI_HALF30 = 64'd1686629713;
  localparam logic [63:0] LN2_30    = 64'd744261118;

  localparam logic [3:0] MODE_LINEAR    = 4'd0;
  localparam logic [3:0] MODE_EXPO_IN   = 4'd1;
  localparam logic [3:0] MODE_EXPO_OUT  = 4'd2;
  localparam logic [3:0] MODE_EXPO_IO   = 4'd3;
  localparam logic [3:0] MODE_SINE_IN   = 4'd4;
  localparam logic [3:0] MODE_SINE_OUT  = 4'd5;
  localparam logic [3:0] MODE_SINE_IO   = 4'd6;
  localparam logic [3:0] MODE_QUAD_IN   = 4'd7;
  localparam logic [3:0] MODE_QUAD_OUT  = 4'd8;
  localparam logic [3:0] MODE_QUAD_IO   = 4'd9;

  localparam logic [2:0] REG_START    = 3'd0;
  localparam logic [2:0] REG_END      = 3'd1;
  localparam logic [2:0] REG_DURATION = 3'd2;
  localparam logic [2:0] REG_REPEAT   = 3'd3;
  localparam logic [2:0] REG_DELAY    = 3'd4;
  localparam logic [2:0] REG_MODE     = 3'd5;
  localparam logic [2:0] REG_PERIOD   = 3'd6;

  typedef enum logic [1:0] {
    MUL_POS,
    MUL_INT,
    MUL_QUAD,
    MUL_BLEND
  } mul_op_t;

  typedef enum logic [1:0] {
    CLS_LINEAR,
    CLS_TABLE,
    CLS_QUAD,
    CLS_NONE
  } mode_cls_t;

  typedef struct packed {
    logic    tick_go;
    logic    div_init;
    logic    div_step;
    logic    mul_en;
    mul_op_t mul_op;
    logic    addr_cap;
    logic    rd_hi;
    logic    lo_cap;
    logic    lk_cap;
    logic    w_cap;
    logic    load_curve;
    logic    load_sec;
    logic    fin;
  } dp_cmd_t;

  typedef struct packed {
    logic      done;
    logic      delay_nz;
    logic      div_last;
    mode_cls_t cls;
    logic      second;
    logic      out_busy;
  } dp_stat_t;

  // sin(x), x in Q2.30 over 0..pi/2
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE30)) sum = longint'(ONE30);
    return 64'(sum);
  endfunction

  // exp(-y), y in Q2.30 over 0..ln 2
  function automatic logic [63:0] expneg_q30(input logic [63:0] y);
    logic [63:0] term;
    longint      sum;
    term = ONE30;
    sum  = longint'(ONE30);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE30)) sum = longint'(ONE30);
    return 64'(sum);
  endfunction

endpackage

// File: rtl/eti_ctrl.sv
// Sequencer for the easing tween: steps the datapath through divide, lookup,
// weighting, blend and result delivery. Depends on eti_pkg.
module eti_ctrl import eti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_frame_tick,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DINIT, S_DIV, S_POS, S_RD0, S_RD1, S_RD2, S_INT, S_LK,
    S_WQ, S_W, S_BLEND, S_RND, S_OUT1, S_SEC, S_OUT2
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   go;

  assign in_ready = (state_r == S_IDLE);
  assign go = in_valid && in_ready && in_frame_tick && !stat.done;

  always_comb begin
    cmd       = '0;
    cmd.mul_op = MUL_POS;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.tick_go = go;
        if (go && !stat.delay_nz) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          case (stat.cls)
            CLS_LINEAR: state_nxt = S_W;
            CLS_TABLE:  state_nxt = S_POS;
            CLS_QUAD:   state_nxt = S_WQ;
            default:    state_nxt = S_SEC;
          endcase
        end
      end
      S_POS: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_POS;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.addr_cap = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: begin
        cmd.rd_hi  = 1'b1;
        cmd.lo_cap = 1'b1;
        state_nxt = S_INT;
      end
      S_INT: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_INT;
        state_nxt = S_LK;
      end
      S_LK: begin
        cmd.lk_cap = 1'b1;
        state_nxt = S_W;
      end
      S_WQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_QUAD;
        state_nxt = S_W;
      end
      S_W: begin
        cmd.w_cap = 1'b1;
        state_nxt = S_BLEND;
      end
      S_BLEND: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_BLEND;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.load_curve = 1'b1;
        state_nxt = S_OUT1;
      end
      S_OUT1: begin
        if (!stat.out_busy) state_nxt = S_SEC;
      end
      S_SEC: begin
        if (stat.second) begin
          cmd.load_sec = 1'b1;
          state_nxt = S_OUT2;
        end else begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT2: begin
        if (!stat.out_busy) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/eti_dp.sv
// Datapath of the easing tween: configuration and tween state, divider, curve
// tables, shared multiplier and output register. Depends on eti_pkg.
module eti_dp import eti_pkg::*; #(
  parameter int CURVE_TABLE_DEPTH = 256,
  parameter int FRACTION_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_last,
  output logic               out_finished
);

  localparam int D  = CURVE_TABLE_DEPTH;
  localparam int FB = FRACTION_BITS;
  localparam int IW = $clog2(D + 1);
  localparam int CW = $clog2(FB + 2);
  localparam logic [30:0] ONE  = 31'h4000_0000;
  localparam logic [30:0] HALF = 31'h2000_0000;

  // configuration
  logic signed [31:0] start_r, end_r;
  logic [15:0] dur_r, period_r;
  logic [3:0]  mode_r;
  // tween state
  logic [23:0] delay_left_r, elapsed_r;
  logic        back_r, done_r;
  logic signed [8:0] reps_r;
  // divider
  logic [24:0] rem_r;
  logic [FB:0] q_r;
  logic [CW-1:0] cnt_r;
  // lookup and arithmetic
  logic [IW-1:0] addr_r;
  logic [29:0]   frac_r;
  logic [30:0]   tab_q, lo_r, lk_r, w_r;
  logic signed [66:0] prod_r;
  logic          out_valid_r, out_last_r, out_fin_r;
  logic signed [31:0] out_value_r;

  logic [30:0] sine_tab [D+1];
  logic [30:0] expo_tab [D+1];

  for (genvar gi = 0; gi <= D; gi++) begin : g_tab
    localparam logic [63:0] E  = 64'(10 * (D - gi));
    localparam logic [63:0] N  = E / D;
    localparam logic [63:0] F  = ((E % D) << 30) / D;
    localparam logic [63:0] SV = sin_q30((PI_HALF30 * gi) / D);
    localparam logic [63:0] EV = expneg_q30((F * LN2_30) >> 30) >> N;
    assign sine_tab[gi] = (gi == 0) ? 31'd0 : ((gi == D) ? ONE : SV[30:0]);
    assign expo_tab[gi] = (gi == D) ? ONE : EV[30:0];
  end

  logic [23:0] dur24, fp24, el_nxt;
  logic [24:0] el_fwd;
  logic [23:0] el_bwd;
  logic        dur_zero;

  assign dur24    = {dur_r, 8'd0};
  assign fp24     = {8'd0, period_r};
  assign dur_zero = (dur_r == 16'd0);
  assign el_fwd   = {1'b0, elapsed_r} + {1'b0, fp24};
  assign el_bwd   = (elapsed_r > fp24) ? elapsed_r - fp24 : 24'd0;

  always_comb begin
    if (back_r) el_nxt = el_bwd;
    else if (el_fwd > {1'b0, dur24}) el_nxt = dur24;
    else el_nxt = el_fwd[23:0];
    if (el_nxt > dur24) el_nxt = dur24;
  end

  // t in Q1.30
  logic [30:0] t30;
  logic        t_one, t_zero, t_lt_half, t_le_half;
  logic [31:0] t2;
  assign t30 = dur_zero ? ONE : {q_r, {(30 - FB){1'b0}}};
  assign t_one     = (t30 == ONE);
  assign t_zero    = (t30 == 31'd0);
  assign t_lt_half = (t30 < HALF);
  assign t_le_half = (t30 <= HALF);
  assign t2        = {t30, 1'b0};

  mode_cls_t cls;
  logic      is_expo;
  always_comb begin
    case (mode_r)
      MODE_LINEAR: cls = CLS_LINEAR;
      MODE_EXPO_IN, MODE_EXPO_OUT, MODE_EXPO_IO,
      MODE_SINE_IN, MODE_SINE_OUT, MODE_SINE_IO: cls = CLS_TABLE;
      MODE_QUAD_IN, MODE_QUAD_OUT, MODE_QUAD_IO: cls = CLS_QUAD;
      default: cls = CLS_NONE;
    endcase
  end
  assign is_expo = (mode_r == MODE_EXPO_IN) || (mode_r == MODE_EXPO_OUT) ||
                   (mode_r == MODE_EXPO_IO);

  // table argument
  logic [30:0] u;
  logic [31:0] u_w;
  always_comb begin
    u_w = {1'b0, t30};
    case (mode_r)
      MODE_EXPO_OUT, MODE_SINE_IN: u_w = {1'b0, ONE - t30};
      MODE_EXPO_IO: u_w = t_lt_half ? t2 : {ONE, 1'b0} - t2;
      MODE_SINE_IO: u_w = t_le_half ? {1'b0, ONE} - t2 : t2 - {1'b0, ONE};
      default: u_w = {1'b0, t30};
    endcase
  end
  assign u = u_w[30:0];

  logic sec_end, sec_ret;
  assign sec_end = t_one && (reps_r == 9'sd0);
  assign sec_ret = !t_one && t_zero && back_r;

  assign stat.done     = done_r;
  assign stat.delay_nz = (delay_left_r != 24'd0);
  assign stat.div_last = (cnt_r == CW'(1));
  assign stat.cls      = cls;
  assign stat.second   = sec_end || sec_ret;
  assign stat.out_busy = out_valid_r;

  // shared multiplier operands
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic [30:0]        r_q;
  logic signed [32:0] span;
  assign r_q  = ONE - t30;
  assign span = 33'(end_r) - 33'(start_r);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_POS: begin
        mul_a = {3'd0, u};
        mul_b = 33'(D);
      end
      MUL_INT: begin
        mul_a = {3'd0, tab_q - lo_r};
        mul_b = {3'd0, frac_r};
      end
      MUL_QUAD: begin
        case (mode_r)
          MODE_QUAD_IN: begin
            mul_a = {3'd0, t30};
            mul_b = {2'd0, t30};
          end
          MODE_QUAD_OUT: begin
            mul_a = {3'd0, t30};
            mul_b = {1'b0, {ONE, 1'b0} - {1'b0, t30}};
          end
          default: begin
            mul_a = t_lt_half ? {2'd0, t2} : {2'd0, r_q, 1'b0};
            mul_b = t_lt_half ? {2'd0, t30} : {2'd0, r_q};
          end
        endcase
      end
      default: begin
        mul_a = {span[32], span};
        mul_b = {2'd0, w_r};
      end
    endcase
  end

  // weight
  logic [30:0] lk, w_nxt, pq;
  logic [31:0] one_plus;
  assign lk       = lo_r + prod_r[60:30];
  assign pq       = prod_r[60:30];
  assign one_plus = {1'b0, ONE} + {1'b0, lk_r};
  always_comb begin
    case (mode_r)
      MODE_EXPO_IN:  w_nxt = t_zero ? 31'd0 : lk_r;
      MODE_EXPO_OUT: w_nxt = t_one ? ONE : ONE - lk_r;
      MODE_EXPO_IO: begin
        if (t_zero) w_nxt = 31'd0;
        else if (t_one) w_nxt = ONE;
        else if (t_lt_half) w_nxt = lk_r >> 1;
        else w_nxt = ONE - (lk_r >> 1);
      end
      MODE_SINE_IN:  w_nxt = ONE - lk_r;
      MODE_SINE_OUT: w_nxt = lk_r;
      MODE_SINE_IO:  w_nxt = t_le_half ? (ONE - lk_r) >> 1 : one_plus[31:1];
      MODE_QUAD_IN, MODE_QUAD_OUT: w_nxt = pq;
      MODE_QUAD_IO:  w_nxt = t_lt_half ? pq : ONE - pq;
      default:       w_nxt = t30;
    endcase
  end

  // round to nearest, ties away from zero
  logic [65:0] mag, rsum;
  logic [31:0] rinc, blend_v;
  assign mag     = prod_r[66] ? 66'(-prod_r) : prod_r[65:0];
  assign rsum    = mag + 66'(HALF);
  assign rinc    = rsum[61:30];
  assign blend_v = prod_r[66] ? start_r - rinc : start_r + rinc;

  logic [IW-1:0] d_idx, hi_addr, rd_addr;
  assign d_idx   = IW'(D);
  assign hi_addr = (addr_r == d_idx) ? d_idx : addr_r + IW'(1);
  assign rd_addr = cmd.rd_hi ? hi_addr : addr_r;

  logic [24:0] rem_sub;
  logic        ge;
  assign ge      = (rem_r >= {1'b0, dur24});
  assign rem_sub = ge ? rem_r - {1'b0, dur24} : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= '0;
      end_r        <= '0;
      dur_r        <= 16'd1000;
      mode_r       <= MODE_LINEAR;
      period_r     <= 16'd4267;
      delay_left_r <= '0;
      elapsed_r    <= '0;
      back_r       <= 1'b0;
      done_r       <= 1'b0;
      reps_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START:    start_r <= cfg_data;
          REG_END:      end_r <= cfg_data;
          REG_DURATION: dur_r <= cfg_data[15:0];
          REG_REPEAT:   reps_r <= cfg_data[8:0];
          REG_DELAY:    delay_left_r <= {cfg_data[15:0], 8'd0};
          REG_MODE:     mode_r <= cfg_data[3:0];
          REG_PERIOD:   period_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.tick_go) begin
        if (delay_left_r != 24'd0)
          delay_left_r <= (delay_left_r > fp24) ? delay_left_r - fp24 : 24'd0;
        else
          elapsed_r <= el_nxt;
      end
      if (cmd.div_init) cnt_r <= CW'(FB + 1);
      else if (cmd.div_step) cnt_r <= cnt_r - CW'(1);
      if (cmd.fin) begin
        if (t_one) begin
          if (reps_r == 9'sd0) done_r <= 1'b1;
          else back_r <= !back_r;
        end else if (t_zero && back_r) begin
          back_r <= 1'b0;
          if (reps_r > 9'sd0) reps_r <= reps_r - 9'sd1;
        end
      end
      if (cmd.load_curve || cmd.load_sec) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= {1'b0, elapsed_r};
      q_r   <= '0;
    end else if (cmd.div_step) begin
      q_r   <= {q_r[FB-1:0], ge};
      rem_r <= {rem_sub[23:0], 1'b0};
    end
    if (cmd.mul_en) prod_r <= 67'(mul_a * mul_b);
    if (cmd.addr_cap) begin
      addr_r <= (u == ONE) ? d_idx : prod_r[30+IW-1:30];
      frac_r <= (u == ONE) ? 30'd0 : prod_r[29:0];
    end
    tab_q <= is_expo ? expo_tab[rd_addr] : sine_tab[rd_addr];
    if (cmd.lo_cap) lo_r <= tab_q;
    if (cmd.lk_cap) lk_r <= lk;
    if (cmd.w_cap) w_r <= w_nxt;
    if (cmd.load_curve) begin
      out_value_r <= blend_v;
      out_last_r  <= !(sec_end || sec_ret);
      out_fin_r   <= 1'b0;
    end else if (cmd.load_sec) begin
      out_value_r <= sec_end ? end_r : start_r;
      out_last_r  <= 1'b1;
      out_fin_r   <= sec_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_finished = out_fin_r;

endmodule

// File: rtl/easing_tween_interpolator_top.sv
// Easing tween interpolator: each accepted frame tick spends the start delay or
// advances elapsed time and emits up to two Q16.16 results. An active tick keeps
// the input busy through the divide, the lookup for the table curves (expo, sine),
// the weighting and the blend, and until each of its results has left the output,
// so an output stall holds the input. The bit-serial divider computes t; table
// read, interpolation, weighting and blend share one multiplier. Delay, idle and
// finished ticks leave the sequencer in its idle state. The block takes one tick
// at a time; results leave through an output register. Depends on eti_pkg.
module easing_tween_interpolator_top import eti_pkg::*; #(
  parameter int CURVE_TABLE_DEPTH = 256,
  parameter int FRACTION_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_frame_tick,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_last,
  output logic               out_finished,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  eti_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_tick (in_frame_tick),
    .in_ready      (in_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  eti_dp #(
    .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for easing_tween_interpolator_top: directed table, then random phases.
// Carries its own tween predictor and curve tables; depends on eti_pkg and the RTL only.
module tb_top import eti_pkg::*;;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 64;
  localparam int TAB_N       = 256;
  localparam int ITEM_GOAL   = 1850;
  localparam logic [63:0] HALF30 = 64'd536870912;

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic        finished;
  } tween_out_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    logic        ft;
    logic        typed;
    logic [31:0] tval;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_frame_tick = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic out_last;
  logic out_finished;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  easing_tween_interpolator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_frame_tick(in_frame_tick),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_last(out_last), .out_finished(out_finished),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state and register copies
  logic [31:0] start_r, end_r;
  logic [15:0] dur_r, period_r;
  logic [3:0]  mode_r;
  logic [31:0] delay_left, elapsed;
  logic        backward, done_r;
  int          repeats_left;
  logic [63:0] sin_tab[0:TAB_N];
  logic [63:0] exp_tab[0:TAB_N];

  tween_out_t due_results[$];
  int  n_checked = 0, n_errors = 0, n_ticks = 0, n_finished = 0, n_returns = 0;
  int  send_idle_pct = 0, stall_pct = 0;
  logic hold = 1'b0;
  logic hold_go = 1'b0;
  int  cyc = 0;

  initial forever #CLK_HALF clk = ~clk;

  function automatic logic [63:0] taylor_sin(logic [63:0] x);
    logic [63:0] x2, term;
    longint acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE30)) acc = longint'(ONE30);
    return 64'(acc);
  endfunction

  function automatic logic [63:0] taylor_expneg(logic [63:0] y);
    logic [63:0] term;
    longint acc;
    term = ONE30;
    acc = longint'(ONE30);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE30)) acc = longint'(ONE30);
    return 64'(acc);
  endfunction

  task automatic fill_curve_tables();
    logic [63:0] e, n, f;
    for (int i = 0; i <= TAB_N; i++) begin
      e = 64'(10 * (TAB_N - i));
      n = e / TAB_N;
      f = ((e % TAB_N) << 30) / TAB_N;
      sin_tab[i] = taylor_sin((PI_HALF30 * i) / TAB_N);
      exp_tab[i] = taylor_expneg((f * LN2_30) >> 30) >> n;
    end
    sin_tab[0] = 0;
    sin_tab[TAB_N] = ONE30;
    exp_tab[TAB_N] = ONE30;
  endtask

  function automatic logic [63:0] curve_read(logic use_sine, logic [63:0] u);
    logic [63:0] pos, idx, frac, a, b;
    if (u >= ONE30) return use_sine ? sin_tab[TAB_N] : exp_tab[TAB_N];
    pos = u * TAB_N;
    idx = pos >> 30;
    frac = pos & (ONE30 - 1);
    if (idx >= TAB_N) return use_sine ? sin_tab[TAB_N] : exp_tab[TAB_N];
    a = use_sine ? sin_tab[idx] : exp_tab[idx];
    b = use_sine ? sin_tab[idx + 1] : exp_tab[idx + 1];
    return a + (((b - a) * frac) >> 30);
  endfunction

  function automatic logic [63:0] curve_weight(logic [3:0] mode, logic [63:0] t);
    logic [63:0] r;
    case (mode)
      MODE_LINEAR: return t;
      MODE_EXPO_IN: return t == 0 ? 64'd0 : curve_read(1'b0, t);
      MODE_EXPO_OUT: return t == ONE30 ? ONE30 : ONE30 - curve_read(1'b0, ONE30 - t);
      MODE_EXPO_IO: begin
        if (t == 0) return 0;
        if (t == ONE30) return ONE30;
        if (t < HALF30) return curve_read(1'b0, 2 * t) >> 1;
        return ONE30 - (curve_read(1'b0, 2 * ONE30 - 2 * t) >> 1);
      end
      MODE_SINE_IN: return ONE30 - curve_read(1'b1, ONE30 - t);
      MODE_SINE_OUT: return curve_read(1'b1, t);
      MODE_SINE_IO: begin
        if (t <= HALF30) return (ONE30 - curve_read(1'b1, ONE30 - 2 * t)) >> 1;
        return (ONE30 + curve_read(1'b1, 2 * t - ONE30)) >> 1;
      end
      MODE_QUAD_IN: return (t * t) >> 30;
      MODE_QUAD_OUT: return (t * (2 * ONE30 - t)) >> 30;
      default: begin
        if (t < HALF30) return (2 * t * t) >> 30;
        r = ONE30 - t;
        return ONE30 - ((2 * r * r) >> 30);
      end
    endcase
  endfunction

  function automatic logic [31:0] mix_value(logic [63:0] w);
    longint s, d, p, v;
    s = longint'($signed(start_r));
    d = longint'($signed(end_r)) - s;
    p = d * longint'(w);
    if (p >= 0) v = s + ((p + longint'(HALF30)) >>> 30);
    else v = s - ((-p + longint'(HALF30)) >>> 30);
    return v[31:0];
  endfunction

  task automatic reset_tween();
    start_r = 0; end_r = 0; dur_r = 16'd1000;
    mode_r = MODE_LINEAR; period_r = 16'd4267;
    delay_left = 0; elapsed = 0; backward = 0; done_r = 0; repeats_left = 0;
  endtask

  task automatic apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_START: start_r = data;
      REG_END: end_r = data;
      REG_DURATION: dur_r = data[15:0];
      REG_REPEAT: repeats_left = int'($signed(data[8:0]));
      REG_DELAY: delay_left = {8'd0, data[15:0], 8'd0};
      REG_MODE: mode_r = data[3:0];
      REG_PERIOD: period_r = data[15:0];
      default: ;
    endcase
  endtask

  // one accepted tick: update state, queue the results it causes
  task automatic advance_tween(logic ft);
    logic [31:0] dur;
    logic [63:0] t;
    tween_out_t r[2];
    int n;
    n = 0;
    if (!ft || done_r) return;
    if (delay_left > 0) begin
      delay_left = delay_left > period_r ? delay_left - period_r : 0;
      return;
    end
    dur = {8'd0, dur_r, 8'd0};
    if (backward) elapsed = elapsed > period_r ? elapsed - period_r : 0;
    else elapsed = elapsed + period_r;
    if (elapsed > dur) elapsed = dur;
    if (dur == 0) t = 64'd1 << 16;
    else t = ({32'd0, elapsed} << 16) / dur;
    t = t << 14;
    if (mode_r <= MODE_QUAD_IO) begin
      r[n] = '{mix_value(curve_weight(mode_r, t)), 1'b1, 1'b0};
      n++;
    end
    if (t >= ONE30) begin
      if (repeats_left == 0) begin
        if (n > 0) r[n-1].last = 1'b0;
        r[n] = '{end_r, 1'b1, 1'b1};
        n++;
        done_r = 1'b1;
      end else begin
        backward = !backward;
      end
    end else if (t == 0 && backward) begin
      if (n > 0) r[n-1].last = 1'b0;
      r[n] = '{start_r, 1'b1, 1'b0};
      n++;
      backward = 1'b0;
      if (repeats_left > 0) repeats_left--;
      n_returns++;
    end
    for (int i = 0; i < n; i++) due_results.push_back(r[i]);
  endtask

  task automatic wait_idle();
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(logic ft, logic typed, logic [31:0] tval);
    int first_new;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_frame_tick <= ft;
    do @(posedge clk); while (!in_ready);
    first_new = due_results.size();
    advance_tween(ft);
    if (typed)
      for (int i = first_new; i < due_results.size(); i++) due_results[i].value = tval;
    n_ticks++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pace(int k);
    case (k % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 56; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 56; end
      default: begin send_idle_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // result side: check each transaction against the oldest expectation
  initial forever begin
    tween_out_t want;
    @(posedge clk);
    if (out_valid && out_ready) begin
      n_checked++;
      if (out_finished) n_finished++;
      if (due_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected result value=%h last=%b finished=%b",
                   out_value, out_last, out_finished);
      end else begin
        want = due_results.pop_front();
        if (out_value !== want.value || out_last !== want.last ||
            out_finished !== want.finished) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d exp value=%h last=%b fin=%b got value=%h last=%b fin=%b",
                     n_checked, want.value, want.last, want.finished,
                     out_value, out_last, out_finished);
        end
      end
    end
    out_ready <= !hold && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  stim_row_t plan[$];

  initial begin
    logic [31:0] v;
    int phase;
    fill_curve_tables();
    reset_tween();
    plan = '{
      '{ROW_TICK, REG_START, 0, 1'b0, 1'b0, 0},
      '{ROW_TICK, REG_START, 0, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_CFG, REG_START, 32'h8000_0000, 0, 0, 0},
      '{ROW_CFG, REG_END, 32'h7FFF_FFFF, 0, 0, 0},
      '{ROW_CFG, REG_DURATION, 0, 0, 0, 0},
      '{ROW_CFG, REG_REPEAT, 32'h0000_01FF, 0, 0, 0},
      '{ROW_TICK, REG_START, 0, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_CFG, REG_START, 32'h7FFF_FFFF, 0, 0, 0},
      '{ROW_CFG, REG_END, 32'h8000_0000, 0, 0, 0},
      '{ROW_TICK, REG_START, 0, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_CFG, REG_START, 32'hFFF0_0000, 0, 0, 0},
      '{ROW_CFG, REG_END, 32'h0064_0000, 0, 0, 0},
      '{ROW_CFG, REG_DURATION, 4, 0, 0, 0},
      '{ROW_CFG, REG_PERIOD, 256, 0, 0, 0},
      '{ROW_CFG, REG_REPEAT, 255, 0, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_EXPO_IN, 0, 0, 0},   '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_EXPO_OUT, 0, 0, 0},  '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_EXPO_IO, 0, 0, 0},   '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_SINE_IN, 0, 0, 0},   '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_SINE_OUT, 0, 0, 0},  '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_SINE_IO, 0, 0, 0},   '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_QUAD_IN, 0, 0, 0},   '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_QUAD_OUT, 0, 0, 0},  '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_QUAD_IO, 0, 0, 0},   '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, 4'd12, 0, 0, 0},
      '{ROW_TICK, 0, 0, 1'b1, 0, 0}, '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_MODE, MODE_LINEAR, 0, 0, 0},
      '{ROW_CFG, REG_DELAY, 2, 0, 0, 0},
      '{ROW_TICK, 0, 0, 1'b1, 0, 0}, '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_PERIOD, 0, 0, 0, 0},
      '{ROW_TICK, 0, 0, 1'b1, 0, 0},
      '{ROW_CFG, REG_REPEAT, 32'h0000_0100, 0, 0, 0},
      '{ROW_CFG, REG_DELAY, 32'hFFFF_0000, 0, 0, 0},
      '{ROW_CFG, REG_PERIOD, 32'h0000_FFFF, 0, 0, 0},
      '{ROW_CFG, REG_DURATION, 32'h0000_FFFF, 0, 0, 0},
      '{ROW_TICK, 0, 0, 1'b1, 0, 0}, '{ROW_TICK, 0, 0, 1'b1, 0, 0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) begin
          end_burst();
          wait_idle();
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].ft, plan[i].typed, plan[i].tval);
      end
    end
    end_burst();

    // random part, phase by phase
    phase = 0;
    while (n_ticks < ITEM_GOAL) begin
      wait_idle();
      set_pace(phase);
      v = $urandom();
      if ($urandom_range(9) == 0) v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      write_reg(REG_START, v);
      v = $urandom();
      if ($urandom_range(9) == 0) v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      write_reg(REG_END, v);
      case ($urandom_range(9))
        0: v = 0;
        1: v = 32'hFFFF;
        2: v = $urandom();
        default: v = {$urandom_range(32'hFFFF) << 16} | $urandom_range(1, 100);
      endcase
      write_reg(REG_DURATION, v);
      // keep the tween alive: endless, or more returns than the phase can use
      if ($urandom_range(1)) v = {$urandom() & 32'hFFFF_FE00} | $urandom_range(256, 511);
      else v = $urandom_range(100, 255);
      write_reg(REG_REPEAT, v);
      v = $urandom_range(2) == 0 ? $urandom_range(0, 300) : 0;
      write_reg(REG_DELAY, v);
      write_reg(REG_MODE, $urandom_range(0, 15) | ($urandom() & 32'hFFFF_FFF0));
      case ($urandom_range(19))
        0: v = 0;
        1: v = 32'hFFFF;
        default: v = $urandom_range(256, 20000);
      endcase
      write_reg(REG_PERIOD, v);
      if (phase == 0) begin
        send_idle_pct = 0;
        stall_pct = 0;
        hold_go = 1'b1;
      end
      repeat ($urandom_range(40, 120))
        send_tick($urandom_range(9) != 0, 1'b0, 0);
      end_burst();
      phase++;
    end

    // run the tween out to its finish, then tick a finished tween
    wait_idle();
    set_pace(3);
    write_reg(REG_REPEAT, 0);
    write_reg(REG_DELAY, 0);
    write_reg(REG_DURATION, 1);
    write_reg(REG_PERIOD, 32'hFFFF);
    write_reg(REG_MODE, MODE_LINEAR);
    repeat (6) send_tick(1'b1, 1'b0, 0);
    end_burst();

    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d ticks over %0d random phases; %0d results checked,",
             n_ticks, phase, n_checked);
    $display("%0d backward returns, %0d finishes, %0d mismatches.",
             n_returns, n_finished, n_errors);
    if (n_errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
